/* hdl/ucw_pkg.sv */
// shared types, constants and helpers for the utf-8 text console
`timescale 1ns / 1ps
`default_nettype none
package ucw_pkg;

   localparam int CP_W   = 21;
   localparam int CELL_W = 22;

   localparam logic [CELL_W-1:0] CONT_MARK = 22'h200000;
   localparam logic [CP_W-1:0]   CP_REPL   = 21'h00fffd;
   localparam logic [CP_W-1:0]   CP_TOP    = 21'h10ffff;
   localparam logic [CP_W-1:0]   SURR_LO   = 21'h00d800;
   localparam logic [CP_W-1:0]   SURR_HI   = 21'h00dfff;

   localparam logic [CP_W-1:0] CP_BACKSPACE = 21'h08;
   localparam logic [CP_W-1:0] CP_TAB       = 21'h09;
   localparam logic [CP_W-1:0] CP_NEWLINE   = 21'h0a;
   localparam logic [CP_W-1:0] CP_RETURN    = 21'h0d;
   localparam logic [CP_W-1:0] CP_SPACE     = 21'h20;
   localparam logic [CP_W-1:0] CP_DEL       = 21'h7f;
   localparam logic [CP_W-1:0] CP_C1_END    = 21'ha0;

   localparam logic [1:0] FUNC_WRITE  = 2'd0;
   localparam logic [1:0] FUNC_SCROLL = 2'd1;
   localparam logic [1:0] FUNC_READ   = 2'd2;
   localparam logic [1:0] FUNC_CLEAR  = 2'd3;

   localparam logic [1:0] CSR_COLUMNS = 2'd0;
   localparam logic [1:0] CSR_ROWS    = 2'd1;
   localparam logic [1:0] CSR_HISTORY = 2'd2;

   localparam logic [6:0] COLS_FLOOR  = 7'd2;
   localparam logic [6:0] COLS_LIMIT  = 7'd120;
   localparam logic [6:0] ROWS_FLOOR  = 7'd1;
   localparam logic [6:0] ROWS_LIMIT  = 7'd80;
   localparam logic [6:0] COLS_RESET  = 7'd80;
   localparam logic [6:0] ROWS_RESET  = 7'd24;
   localparam logic [8:0] HIST_RESET  = 9'd256;

   typedef struct packed {
      logic init;
      logic flush;
      logic take;
   } dec_ctrl_type;

   typedef struct packed {
      logic [1:0]      count;
      logic [CP_W-1:0] cp0;
      logic [CP_W-1:0] cp1;
   } dec_out_type;

   // double-width ranges
   function automatic logic is_wide(input logic [CP_W-1:0] cp);
      logic w;
      w = 1'b0;
      if (cp >= 21'h1100) begin
         w = (cp <= 21'h115f) || cp == 21'h2329 || cp == 21'h232a ||
             (cp >= 21'h2e80 && cp <= 21'ha4cf && cp != 21'h303f) ||
             (cp >= 21'hac00 && cp <= 21'hd7a3) || (cp >= 21'hf900 && cp <= 21'hfaff) ||
             (cp >= 21'hfe10 && cp <= 21'hfe19) || (cp >= 21'hfe30 && cp <= 21'hfe6f) ||
             (cp >= 21'hff00 && cp <= 21'hff60) || (cp >= 21'hffe0 && cp <= 21'hffe6) ||
             (cp >= 21'h1f300 && cp <= 21'h1faff) || (cp >= 21'h20000 && cp <= 21'h3fffd);
      end
      return w;
   endfunction

endpackage
`default_nettype wire

/* hdl/utf8_text_console_writer.sv */
// utf-8 text console: sequencer around the cell store and the utf-8 decoder
//
// Input channel req_*: one transaction per item (func selects write byte, scroll,
// read cell or clear). Result channel rsp_*: exactly one transaction per item that
// no csr write cuts off, carrying the cell read and the cursor, line count and view
// top after the item. A csr_* write to columns, rows or history sets that register and restarts the console.
// Items are taken one at a time; the cell store has one read and one write port
// and every cell access is a separate cycle, so the time an item takes follows the
// work: a newline, a wrap and a clear each blank the columns in use of the line they
// start, a tab writes one space per column up to the next tab stop, and a printable
// or backspace reads the cells around the cursor before it writes.
// A byte that cuts a sequence off runs the replacement and then its own character.
// A finished result sits in the rsp register; the next item is accepted while it
// waits, and only a following completion holds while rsp_stall stays high.
// Reset and every csr write that restarts the console clear the columns in use
// (at most 120) of the newest line, during which req_stall is high; older lines are
// cleared as they come back into use.
`timescale 1ns / 1ps
`default_nettype none
module utf8_text_console_writer #(
   parameter int MAX_COLUMNS = 128,
   parameter int MAX_HISTORY = 256,
   parameter int TAB_STOP    = 8
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_func,
   input  wire  [7:0]  req_data_byte,
   input  wire  [9:0]  req_scroll_lines,
   input  wire  [7:0]  req_history_line,
   input  wire  [6:0]  req_cell_column,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [20:0] rsp_cell_value,
   output logic [6:0]  rsp_cursor_col,
   output logic [8:0]  rsp_kept_lines,
   output logic [7:0]  rsp_first_visible,
   input  wire         csr_write_enable,
   input  wire  [1:0]  csr_index,
   input  wire  [8:0]  csr_write_data
);

   localparam int COL_W  = $clog2(MAX_COLUMNS);
   localparam int SLOT_W = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
   localparam int ADDR_W = SLOT_W + COL_W;
   localparam int TAB_W  = $clog2(TAB_STOP + 1);
   localparam int PH_W   = $clog2(TAB_STOP);

   typedef enum logic [4:0] {
      ST_IDLE, ST_SWEEP, ST_DISPATCH, ST_NL, ST_PR_CHECK,
      ST_PR_RD0, ST_PR_RD1, ST_PR_RD2, ST_PR_RD3,
      ST_PR_WA, ST_PR_WB, ST_PR_WC, ST_PR_WD,
      ST_BS_RD, ST_BS_CHK, ST_BS_RD0, ST_BS_RD1, ST_BS_RD2,
      ST_BS_WA, ST_BS_WB, ST_BS_WC,
      ST_RD_DATA, ST_DONE
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;

   logic [6:0]  cfg_cols_ff, cfg_cols_in;
   logic [6:0]  cfg_rows_ff, cfg_rows_in;
   logic [8:0]  cfg_hist_ff, cfg_hist_in;

   logic [6:0]  col_ff, col_in;
   logic [PH_W-1:0] phase_ff, phase_in;
   logic [8:0]  newest_ff, newest_in;
   logic [8:0]  kept_ff, kept_in;
   logic [8:0]  view_ff, view_in;
   logic [6:0]  clr_ff, clr_in;

   logic [1:0]  cnt_ff, cnt_in;
   logic [1:0]  idx_ff, idx_in;
   logic [20:0] cp0_ff, cp0_in;
   logic [20:0] cp1_ff, cp1_in;
   logic [20:0] cur_ff, cur_in;
   logic        wide_ff, wide_in;
   logic [TAB_W-1:0] tab_left_ff, tab_left_in;
   logic [21:0] a_ff, a_in;
   logic [21:0] b_ff, b_in;
   logic [21:0] c_ff, c_in;
   logic        rd_ok_ff, rd_ok_in;
   logic [20:0] res_ff, res_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [20:0] rsp_cell_ff, rsp_cell_in;
   logic [6:0]  rsp_col_ff, rsp_col_in;
   logic [8:0]  rsp_kept_ff, rsp_kept_in;
   logic [7:0]  rsp_view_ff, rsp_view_in;

   logic [6:0]  cols_eff;
   logic [6:0]  rows_eff;
   logic [8:0]  hist_eff;
   logic [8:0]  bottom;

   logic                     wr_en;
   logic [ADDR_W-1:0]        wr_addr;
   logic [ucw_pkg::CELL_W-1:0] wr_data;
   logic [ADDR_W-1:0]        rd_addr;
   logic [ucw_pkg::CELL_W-1:0] rd_data;

   ucw_pkg::dec_ctrl_type dec_ctrl;
   ucw_pkg::dec_out_type  dec_out;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [8:0] slot,
                                                   input logic [6:0] col);
      return {SLOT_W'(slot), COL_W'(col)};
   endfunction

   function automatic logic [PH_W-1:0] ph_dec(input logic [PH_W-1:0] p);
      return (p == '0) ? PH_W'(TAB_STOP - 1) : p - PH_W'(1);
   endfunction

   function automatic logic [PH_W-1:0] ph_add(input logic [PH_W-1:0] p,
                                              input logic [1:0] w);
      logic [PH_W:0] s;
      s = {1'b0, p} + (PH_W + 1)'(w);
      if (s >= (PH_W + 1)'(TAB_STOP)) begin
         s = s - (PH_W + 1)'(TAB_STOP);
      end
      return s[PH_W-1:0];
   endfunction

   // effective geometry
   always_comb begin
      cols_eff = cfg_cols_ff;
      if (cols_eff < ucw_pkg::COLS_FLOOR) cols_eff = ucw_pkg::COLS_FLOOR;
      if (cols_eff > ucw_pkg::COLS_LIMIT) cols_eff = ucw_pkg::COLS_LIMIT;
      if (int'(cols_eff) > MAX_COLUMNS) cols_eff = 7'(MAX_COLUMNS);
      rows_eff = cfg_rows_ff;
      if (rows_eff < ucw_pkg::ROWS_FLOOR) rows_eff = ucw_pkg::ROWS_FLOOR;
      if (rows_eff > ucw_pkg::ROWS_LIMIT) rows_eff = ucw_pkg::ROWS_LIMIT;
      hist_eff = cfg_hist_ff;
      if (hist_eff < {2'd0, rows_eff}) hist_eff = {2'd0, rows_eff};
      if (int'(hist_eff) > MAX_HISTORY) hist_eff = 9'(MAX_HISTORY);
      bottom = (kept_ff > {2'd0, rows_eff}) ? kept_ff - {2'd0, rows_eff} : 9'd0;
   end

   ucw_cell_ram #(
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ucw_utf8_decoder u_dec (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (dec_ctrl),
      .data_byte (req_data_byte),
      .dec_out   (dec_out)
   );

   always_comb begin
      logic        accept;
      logic        csr_hit;
      logic [20:0] cp;
      logic [8:0]  kept_nl;
      logic [8:0]  bottom_nl;
      logic [9:0]  newest_inc;
      logic [10:0] h_s;
      logic [10:0] lines;
      logic [10:0] next_v;
      logic [8:0]  back_n;
      logic [9:0]  slot_w;
      logic [8:0]  slot;
      logic [6:0]  cm;
      logic [7:0]  col_ext;
      logic [7:0]  cols_ext;

      state_in = state_ff;
      ret_in = ret_ff;
      cfg_cols_in = cfg_cols_ff;
      cfg_rows_in = cfg_rows_ff;
      cfg_hist_in = cfg_hist_ff;
      col_in = col_ff;
      phase_in = phase_ff;
      newest_in = newest_ff;
      kept_in = kept_ff;
      view_in = view_ff;
      clr_in = clr_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      cp0_in = cp0_ff;
      cp1_in = cp1_ff;
      cur_in = cur_ff;
      wide_in = wide_ff;
      tab_left_in = tab_left_ff;
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      rd_ok_in = rd_ok_ff;
      res_in = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_cell_in = rsp_cell_ff;
      rsp_col_in = rsp_col_ff;
      rsp_kept_in = rsp_kept_ff;
      rsp_view_in = rsp_view_ff;
      dec_ctrl = '0;
      wr_en = 1'b0;
      wr_addr = cell_addr(newest_ff, col_ff);
      wr_data = '0;
      rd_addr = cell_addr(newest_ff, col_ff);
      cp = '0;
      col_ext = {1'b0, col_ff};
      cols_ext = {1'b0, cols_eff};
      cm = col_ff - 7'd1;

      accept = req_valid && !req_stall;
      csr_hit = csr_write_enable && (csr_index == ucw_pkg::CSR_COLUMNS ||
                csr_index == ucw_pkg::CSR_ROWS || csr_index == ucw_pkg::CSR_HISTORY);

      // newline targets
      newest_inc = {1'b0, newest_ff} + 10'd1;
      kept_nl = (kept_ff < hist_eff) ? kept_ff + 9'd1 : kept_ff;
      bottom_nl = (kept_nl > {2'd0, rows_eff}) ? kept_nl - {2'd0, rows_eff} : 9'd0;

      // scroll
      h_s = {2'd0, hist_eff};
      lines = {req_scroll_lines[9], req_scroll_lines};
      if ($signed(lines) > $signed(h_s)) lines = h_s;
      if ($signed(lines) < -$signed(h_s)) lines = -h_s;
      next_v = {2'd0, view_ff} - lines;
      if ($signed(next_v) > $signed({2'd0, bottom})) next_v = {2'd0, bottom};
      if ($signed(next_v) < 0) next_v = '0;

      // read slot, counted back from the newest line
      back_n = kept_ff - 9'd1 - {1'b0, req_history_line};
      slot_w = (newest_ff >= back_n) ? {1'b0, newest_ff} - {1'b0, back_n}
                                     : {1'b0, newest_ff} + {1'b0, hist_eff} - {1'b0, back_n};
      slot = slot_w[8:0];

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = cell_addr(slot, req_cell_column);
            if (accept) begin
               res_in = '0;
               unique case (req_func)
                  ucw_pkg::FUNC_WRITE: begin
                     dec_ctrl.take = 1'b1;
                     cnt_in = dec_out.count;
                     cp0_in = dec_out.cp0;
                     cp1_in = dec_out.cp1;
                     idx_in = '0;
                     state_in = ST_DISPATCH;
                  end
                  ucw_pkg::FUNC_SCROLL: begin
                     view_in = next_v[8:0];
                     state_in = ST_DONE;
                  end
                  ucw_pkg::FUNC_READ: begin
                     rd_ok_in = {1'b0, req_history_line} < kept_ff && req_cell_column < cols_eff;
                     state_in = ST_RD_DATA;
                  end
                  default: begin
                     dec_ctrl.flush = 1'b1;
                     col_in = '0;
                     phase_in = '0;
                     newest_in = '0;
                     kept_in = 9'd1;
                     view_in = '0;
                     clr_in = '0;
                     ret_in = ST_DONE;
                     state_in = ST_SWEEP;
                  end
               endcase
            end
         end
         ST_RD_DATA: begin
            res_in = (rd_ok_ff && rd_data != ucw_pkg::CONT_MARK) ? rd_data[20:0] : 21'd0;
            state_in = ST_DONE;
         end
         ST_SWEEP: begin
            wr_en = 1'b1;
            wr_addr = cell_addr(newest_ff, clr_ff);
            if (clr_ff == cols_eff - 7'd1) begin
               state_in = ret_ff;
            end else begin
               clr_in = clr_ff + 7'd1;
            end
         end
         ST_NL: begin
            newest_in = (newest_inc == {1'b0, hist_eff}) ? 9'd0 : newest_inc[8:0];
            kept_in = kept_nl;
            if (kept_ff >= hist_eff && view_ff != 9'd0) view_in = view_ff - 9'd1;
            if (view_ff == bottom) view_in = bottom_nl;
            col_in = '0;
            phase_in = '0;
            clr_in = '0;
            state_in = ST_SWEEP;
         end
         ST_DISPATCH: begin
            if (idx_ff == cnt_ff) begin
               state_in = ST_DONE;
            end else begin
               cp = (idx_ff == 2'd0) ? cp0_ff : cp1_ff;
               idx_in = idx_ff + 2'd1;
               if (cp == ucw_pkg::CP_NEWLINE) begin
                  ret_in = ST_DISPATCH;
                  state_in = ST_NL;
               end else if (cp == ucw_pkg::CP_RETURN) begin
                  col_in = '0;
                  phase_in = '0;
               end else if (cp == ucw_pkg::CP_BACKSPACE) begin
                  if (col_ff != 7'd0) state_in = ST_BS_RD;
               end else if (cp == ucw_pkg::CP_TAB) begin
                  cur_in = ucw_pkg::CP_SPACE;
                  wide_in = 1'b0;
                  tab_left_in = TAB_W'(TAB_STOP) - TAB_W'(phase_ff);
                  state_in = ST_PR_CHECK;
               end else if (cp < ucw_pkg::CP_SPACE ||
                            (cp >= ucw_pkg::CP_DEL && cp < ucw_pkg::CP_C1_END)) begin
                  state_in = ST_DISPATCH;
               end else begin
                  cur_in = cp;
                  wide_in = ucw_pkg::is_wide(cp);
                  tab_left_in = TAB_W'(1);
                  state_in = ST_PR_CHECK;
               end
            end
         end
         ST_PR_CHECK: begin
            if (col_ext + (wide_ff ? 8'd2 : 8'd1) > cols_ext) begin
               ret_in = ST_PR_RD0;
               state_in = ST_NL;
            end else begin
               state_in = ST_PR_RD0;
            end
         end
         ST_PR_RD0: begin
            state_in = ST_PR_RD1;
         end
         ST_PR_RD1: begin
            a_in = rd_data;
            rd_addr = cell_addr(newest_ff, col_ff + 7'd1);
            state_in = ST_PR_RD2;
         end
         ST_PR_RD2: begin
            b_in = rd_data;
            rd_addr = cell_addr(newest_ff, col_ff + 7'd2);
            state_in = ST_PR_RD3;
         end
         ST_PR_RD3: begin
            c_in = rd_data;
            state_in = ST_PR_WA;
         end
         ST_PR_WA: begin
            // old continuation under the cursor: drop its lead
            wr_en = a_ff == ucw_pkg::CONT_MARK && col_ff != 7'd0;
            wr_addr = cell_addr(newest_ff, cm);
            state_in = ST_PR_WB;
         end
         ST_PR_WB: begin
            // old wide character cut in half: drop its trailing continuation
            if (wide_ff) begin
               wr_en = b_ff != '0 && b_ff != ucw_pkg::CONT_MARK &&
                       col_ext + 8'd2 < cols_ext && c_ff == ucw_pkg::CONT_MARK;
               wr_addr = cell_addr(newest_ff, col_ff + 7'd2);
            end else begin
               wr_en = a_ff != '0 && a_ff != ucw_pkg::CONT_MARK &&
                       col_ext + 8'd1 < cols_ext && b_ff == ucw_pkg::CONT_MARK;
               wr_addr = cell_addr(newest_ff, col_ff + 7'd1);
            end
            state_in = ST_PR_WC;
         end
         ST_PR_WC: begin
            wr_en = 1'b1;
            wr_data = {1'b0, cur_ff};
            if (wide_ff) begin
               state_in = ST_PR_WD;
            end else begin
               col_in = col_ff + 7'd1;
               phase_in = ph_add(phase_ff, 2'd1);
               if (tab_left_ff == TAB_W'(1)) begin
                  state_in = ST_DISPATCH;
               end else begin
                  tab_left_in = tab_left_ff - TAB_W'(1);
                  state_in = ST_PR_CHECK;
               end
            end
         end
         ST_PR_WD: begin
            wr_en = 1'b1;
            wr_addr = cell_addr(newest_ff, col_ff + 7'd1);
            wr_data = ucw_pkg::CONT_MARK;
            col_in = col_ff + 7'd2;
            phase_in = ph_add(phase_ff, 2'd2);
            state_in = ST_DISPATCH;
         end
         ST_BS_RD: begin
            rd_addr = cell_addr(newest_ff, cm);
            state_in = ST_BS_CHK;
         end
         ST_BS_CHK: begin
            // step over the continuation of a wide pair
            if (rd_data == ucw_pkg::CONT_MARK && cm != 7'd0) begin
               col_in = col_ff - 7'd2;
               phase_in = ph_dec(ph_dec(phase_ff));
            end else begin
               col_in = cm;
               phase_in = ph_dec(phase_ff);
            end
            state_in = ST_BS_RD0;
         end
         ST_BS_RD0: begin
            state_in = ST_BS_RD1;
         end
         ST_BS_RD1: begin
            a_in = rd_data;
            rd_addr = cell_addr(newest_ff, col_ff + 7'd1);
            state_in = ST_BS_RD2;
         end
         ST_BS_RD2: begin
            b_in = rd_data;
            state_in = ST_BS_WA;
         end
         ST_BS_WA: begin
            wr_en = a_ff == ucw_pkg::CONT_MARK && col_ff != 7'd0;
            wr_addr = cell_addr(newest_ff, cm);
            state_in = ST_BS_WB;
         end
         ST_BS_WB: begin
            wr_en = a_ff != '0 && a_ff != ucw_pkg::CONT_MARK &&
                    col_ext + 8'd1 < cols_ext && b_ff == ucw_pkg::CONT_MARK;
            wr_addr = cell_addr(newest_ff, col_ff + 7'd1);
            state_in = ST_BS_WC;
         end
         ST_BS_WC: begin
            wr_en = a_ff != '0;
            state_in = ST_DISPATCH;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_cell_in = res_ff;
               rsp_col_in = col_ff;
               rsp_kept_in = kept_ff;
               rsp_view_in = view_ff[7:0];
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a register write restarts the console
      if (csr_hit) begin
         unique case (csr_index)
            ucw_pkg::CSR_COLUMNS: cfg_cols_in = csr_write_data[6:0];
            ucw_pkg::CSR_ROWS:    cfg_rows_in = csr_write_data[6:0];
            default:              cfg_hist_in = csr_write_data;
         endcase
         dec_ctrl = '0;
         dec_ctrl.init = 1'b1;
         col_in = '0;
         phase_in = '0;
         newest_in = '0;
         kept_in = 9'd1;
         view_in = '0;
         clr_in = '0;
         ret_in = ST_IDLE;
         state_in = ST_SWEEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         ret_ff <= ST_IDLE;
         cfg_cols_ff <= ucw_pkg::COLS_RESET;
         cfg_rows_ff <= ucw_pkg::ROWS_RESET;
         cfg_hist_ff <= ucw_pkg::HIST_RESET;
         col_ff <= '0;
         phase_ff <= '0;
         newest_ff <= '0;
         kept_ff <= 9'd1;
         view_ff <= '0;
         clr_ff <= '0;
         cnt_ff <= '0;
         idx_ff <= '0;
         tab_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         cfg_cols_ff <= cfg_cols_in;
         cfg_rows_ff <= cfg_rows_in;
         cfg_hist_ff <= cfg_hist_in;
         col_ff <= col_in;
         phase_ff <= phase_in;
         newest_ff <= newest_in;
         kept_ff <= kept_in;
         view_ff <= view_in;
         clr_ff <= clr_in;
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
         tab_left_ff <= tab_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cp0_ff <= cp0_in;
      cp1_ff <= cp1_in;
      cur_ff <= cur_in;
      wide_ff <= wide_in;
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      rd_ok_ff <= rd_ok_in;
      res_ff <= res_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_col_ff <= rsp_col_in;
      rsp_kept_ff <= rsp_kept_in;
      rsp_view_ff <= rsp_view_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_cell_value = rsp_cell_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_kept_lines = rsp_kept_ff;
   assign rsp_first_visible = rsp_view_ff;

endmodule
`default_nettype wire

/* hdl/ucw_cell_ram.sv */
// cell store: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module ucw_cell_ram #(
   parameter int ADDR_W = 15
) (
   input  wire                          clock,
   input  wire                          wr_en,
   input  wire  [ADDR_W-1:0]            wr_addr,
   input  wire  [ucw_pkg::CELL_W-1:0]   wr_data,
   input  wire  [ADDR_W-1:0]            rd_addr,
   output logic [ucw_pkg::CELL_W-1:0]   rd_data
);

   logic [ucw_pkg::CELL_W-1:0] mem [2**ADDR_W];
   logic [ucw_pkg::CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hdl/ucw_utf8_decoder.sv */
// utf-8 byte decoder: holds the pending sequence, yields up to two code points per byte
`timescale 1ns / 1ps
`default_nettype none
module ucw_utf8_decoder (
   input  wire                    clock,
   input  wire                    reset,
   input  ucw_pkg::dec_ctrl_type  ctrl,
   input  wire  [7:0]             data_byte,
   output ucw_pkg::dec_out_type   dec_out
);

   logic [20:0] acc_ff, acc_in;
   logic [16:0] min_ff, min_in;
   logic [1:0]  pend_ff, pend_in;

   always_comb begin
      logic [20:0]      acc_n;
      logic [16:0]      min_n;
      logic [1:0]       pend_n;
      logic             fresh;
      logic             bad;
      logic             emit_fresh;
      logic [20:0]      fresh_cp;
      dec_out = '0;
      acc_n = acc_ff;
      min_n = min_ff;
      pend_n = pend_ff;
      fresh = 1'b1;
      bad = 1'b0;
      emit_fresh = 1'b0;
      fresh_cp = '0;
      if (pend_ff != 2'd0) begin
         if (data_byte[7:6] == 2'b10) begin
            fresh = 1'b0;
            acc_n = {acc_ff[14:0], data_byte[5:0]};
            pend_n = pend_ff - 2'd1;
            if (pend_ff == 2'd1) begin
               bad = acc_n < {4'd0, min_ff} || acc_n > ucw_pkg::CP_TOP ||
                     (acc_n >= ucw_pkg::SURR_LO && acc_n <= ucw_pkg::SURR_HI);
               dec_out.cp0 = bad ? ucw_pkg::CP_REPL : acc_n;
               dec_out.count = 2'd1;
            end
         end else begin
            // sequence cut short
            pend_n = 2'd0;
            dec_out.cp0 = ucw_pkg::CP_REPL;
            dec_out.count = 2'd1;
         end
      end
      if (fresh) begin
         if (data_byte < 8'h80) begin
            emit_fresh = 1'b1;
            fresh_cp = {13'd0, data_byte};
         end else if (data_byte >= 8'hc2 && data_byte <= 8'hdf) begin
            acc_n = {16'd0, data_byte[4:0]};
            min_n = 17'h00080;
            pend_n = 2'd1;
         end else if (data_byte >= 8'he0 && data_byte <= 8'hef) begin
            acc_n = {17'd0, data_byte[3:0]};
            min_n = 17'h00800;
            pend_n = 2'd2;
         end else if (data_byte >= 8'hf0 && data_byte <= 8'hf4) begin
            acc_n = {18'd0, data_byte[2:0]};
            min_n = 17'h10000;
            pend_n = 2'd3;
         end else begin
            emit_fresh = 1'b1;
            fresh_cp = ucw_pkg::CP_REPL;
         end
         if (emit_fresh) begin
            if (dec_out.count == 2'd0) begin
               dec_out.cp0 = fresh_cp;
            end else begin
               dec_out.cp1 = fresh_cp;
            end
            dec_out.count = dec_out.count + 2'd1;
         end
      end
      acc_in = acc_ff;
      min_in = min_ff;
      pend_in = pend_ff;
      if (ctrl.init) begin
         acc_in = '0;
         min_in = '0;
         pend_in = '0;
      end else if (ctrl.flush) begin
         pend_in = '0;
      end else if (ctrl.take) begin
         acc_in = acc_n;
         min_in = min_n;
         pend_in = pend_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         min_ff <= '0;
         pend_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         min_ff <= min_in;
         pend_ff <= pend_in;
      end
   end

endmodule
`default_nettype wire
